// ===== rtl/sem_pkg.sv =====
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies; used by sem_mag and sobel_edge_magnitude_top.
`timescale 1ns / 1ps

package sem_pkg;

    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 13;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam int MAG_BITS       = 11;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 13'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic row_end;
        logic frame_end;
    } tag_t;

endpackage

// ===== rtl/sem_mag.sv =====
// Magnitude pipeline: squares the two gradients, sums them and takes the
// floor square root, one result bit per stage. Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_mag #(
    parameter int PIXEL_BITS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          grad_valid,
    output logic                          grad_ready,
    input  logic signed [PIXEL_BITS+2:0]  gx,
    input  logic signed [PIXEL_BITS+2:0]  gy,
    input  sem_pkg::tag_t                 grad_tag,
    output logic                          mag_valid,
    input  logic                          mag_stall,
    output logic [sem_pkg::MAG_BITS-1:0]  magnitude,
    output sem_pkg::tag_t                 mag_tag
);

    localparam int GW = PIXEL_BITS + 3;     // signed gradient
    localparam int SQ = 2 * PIXEL_BITS + 4; // one square
    localparam int XW = SQ + 1;             // sum of squares
    localparam int RW = PIXEL_BITS + 3;     // root bits, one stage each
    localparam int NS = RW + 3;             // gradient, square, sum, roots

    logic [NS-1:0]          valid_reg;
    sem_pkg::tag_t          tag_reg [NS];
    logic signed [GW-1:0]   gx_reg;
    logic signed [GW-1:0]   gy_reg;
    logic [SQ-1:0]          sqx_reg;
    logic [SQ-1:0]          sqy_reg;
    logic [XW-1:0]          x_reg [RW+1];
    logic [XW-1:0]          r_reg [RW+1];
    logic [XW-1:0]          x_next [RW];
    logic [XW-1:0]          r_next [RW];
    logic signed [2*GW-1:0] prod_x;
    logic signed [2*GW-1:0] prod_y;
    logic                   en;

    // advance the whole pipe unless the output beat is held
    assign en         = !valid_reg[NS-1] || !mag_stall;
    assign grad_ready = en;

    always_comb
    begin
        prod_x = gx_reg * gx_reg;
        prod_y = gy_reg * gy_reg;
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_root
        localparam logic [XW-1:0] STEP_BIT = XW'(1) << (2 * (RW - 1 - k));
        logic [XW:0] trial;

        always_comb
        begin
            trial = {1'b0, r_reg[k]} + {1'b0, STEP_BIT};
            if ({1'b0, x_reg[k]} >= trial)
            begin
                x_next[k] = x_reg[k] - trial[XW-1:0];
                r_next[k] = (r_reg[k] >> 1) + STEP_BIT;
            end
            else
            begin
                x_next[k] = x_reg[k];
                r_next[k] = r_reg[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NS-2:0], grad_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg[0] <= grad_tag;
            for (int s = 1; s < NS; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
            gx_reg   <= gx;
            gy_reg   <= gy;
            sqx_reg  <= prod_x[SQ-1:0];
            sqy_reg  <= prod_y[SQ-1:0];
            x_reg[0] <= XW'(sqx_reg) + XW'(sqy_reg);
            r_reg[0] <= '0;
            for (int k = 0; k < RW; k++)
            begin
                x_reg[k+1] <= x_next[k];
                r_reg[k+1] <= r_next[k];
            end
        end
    end

    assign mag_valid = valid_reg[NS-1];
    assign magnitude = sem_pkg::MAG_BITS'(r_reg[RW]);
    assign mag_tag   = tag_reg[NS-1];

endmodule

// ===== rtl/sobel_edge_magnitude_top.sv =====
// Sobel edge magnitude block: line memories, 3x3 window and position logic.
// Depends on sem_pkg and sem_mag.
`timescale 1ns / 1ps

// Streams 8-bit grey pixels of a frame_width x frame_height frame in raster
// order and returns floor(sqrt(gx^2 + gy^2)) of the 3x3 Sobel gradients for
// each pixel, with neighbors outside the frame counted as zero. The block
// takes one pixel beat per clock while the result side keeps up: the two
// line memories (one read port, one write port each) are read when a pixel
// is accepted and written back when that beat leaves the window stage, with
// a bypass when the next pixel hits the same column, so the read-modify-write
// of the line store sets the rate. Results come out in pixel order, one row
// plus one pixel behind the input in beat count; after the last pixel of a
// frame, send frame_width+1 beats with pad set to flush the last results.
// A result released by a beat passes in order through the window stage,
// the gradient registers, the squares, their sum and the root stages
// before it leaves the pipeline. row_end and frame_end
// mark the last result of a row and of the frame; the block then starts a
// new frame. Change frame_width or frame_height only between frames. The
// line memories power up undefined and need no clearing pass: border masking
// keeps stale entries out of every result.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sem_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                pix_valid,
    output logic                                pix_stall,
    input  logic [PIXEL_BITS-1:0]               pixel,
    input  logic                                pad,
    output logic                                mag_valid,
    input  logic                                mag_stall,
    output logic [sem_pkg::MAG_BITS-1:0]        magnitude,
    output logic                                row_end,
    output logic                                frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);  // column index
    localparam int WW = CW + 1;             // effective width
    localparam int FW = (WW > sem_pkg::WIDTH_BITS) ? WW : sem_pkg::WIDTH_BITS;
    localparam int RB = sem_pkg::HEIGHT_BITS;
    localparam int GW = PIXEL_BITS + 3;

    // position flags of one beat, worked out when it is accepted
    typedef struct packed {
        logic emit;
        logic zl;        // left column outside the frame
        logic zr;        // right column outside the frame
        logic zt;        // top row outside the frame
        logic zb;        // bottom row outside the frame
        logic row_end;
        logic frame_end;
    } pos_t;

    // configuration
    logic [sem_pkg::WIDTH_BITS-1:0]  frame_width_reg;
    logic [sem_pkg::HEIGHT_BITS-1:0] frame_height_reg;
    logic [FW-1:0]                   fw_ext;
    logic [WW-1:0]                   w_eff;
    logic [RB-1:0]                   h_eff;

    // position counters
    logic [CW-1:0] in_col_reg, in_col_next;
    logic [RB-1:0] in_row_reg, in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RB-1:0] out_row_reg, out_row_next;

    // accept stage
    logic                  pix_accept;
    logic                  col_wrap, oc_wrap;
    logic [CW-1:0]         col, oc;
    logic [RB-1:0]         row, orow;
    logic [WW-1:0]         col_inc, oc_inc;
    logic [RB:0]           orow_inc;
    logic                  oc_end, or_end;
    logic [PIXEL_BITS-1:0] v_in;
    pos_t                  pos;

    // line memories and bypass
    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] rd_up_reg, rd_lo_reg;
    logic                  fwd_reg, fwd_next;
    logic [PIXEL_BITS-1:0] fwd_up_reg, fwd_lo_reg;

    // window stage
    logic                                b_valid_reg, b_valid_next;
    logic [PIXEL_BITS-1:0]               b_pix_reg;
    logic [CW-1:0]                       b_col_reg;
    pos_t                                b_pos_reg;
    logic                                b_commit;
    logic [2:0][1:0][PIXEL_BITS-1:0]     win_reg, win_next;
    logic [PIXEL_BITS-1:0]               up_cur, lo_cur;
    logic [PIXEL_BITS-1:0]               n00, n01, n02, n10, n12, n20, n21, n22;
    logic [GW-1:0]                       top_sum, bot_sum, left_sum, right_sum;
    logic signed [GW-1:0]                gx, gy;
    sem_pkg::tag_t                       grad_tag, mag_tag;
    logic                                grad_ready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sem_pkg::WIDTH_RESET;
            frame_height_reg <= sem_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (sem_pkg::cfg_index_t'(cfg_index))
                sem_pkg::CFG_FRAME_WIDTH:
                    frame_width_reg <= cfg_data[sem_pkg::WIDTH_BITS-1:0];
                sem_pkg::CFG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_data[sem_pkg::HEIGHT_BITS-1:0];
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to at least 1.
    always_comb
    begin
        fw_ext = FW'(frame_width_reg);
        if (fw_ext == '0)
            w_eff = WW'(1);
        else if (fw_ext > FW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = fw_ext[WW-1:0];
        h_eff = (frame_height_reg == '0) ? RB'(1) : frame_height_reg;
    end

    // ------------------------------------------------------------------
    // Accept stage: positions, border masks and counter update
    // ------------------------------------------------------------------
    always_comb
    begin
        // wrap counters left beyond a narrowed width
        col_wrap = {1'b0, in_col_reg} >= w_eff;
        col      = col_wrap ? '0 : in_col_reg;
        row      = in_row_reg;
        if (col_wrap && in_row_reg != '1)
            row = in_row_reg + 1'b1;

        oc_wrap = {1'b0, out_col_reg} >= w_eff;
        oc      = oc_wrap ? '0 : out_col_reg;
        orow    = oc_wrap ? out_row_reg + 1'b1 : out_row_reg;

        // pad beats and rows below the frame stand for zero pixels
        v_in = (pad || row >= h_eff) ? '0 : pixel;

        col_inc  = {1'b0, col} + 1'b1;
        oc_inc   = {1'b0, oc} + 1'b1;
        orow_inc = {1'b0, orow} + 1'b1;
        oc_end   = oc_inc >= w_eff;
        or_end   = orow_inc >= {1'b0, h_eff};

        pos.emit      = (row >= RB'(2)) || (row == RB'(1) && col != '0);
        pos.zl        = oc == '0;
        pos.zr        = (col == '0) || oc_end;
        pos.zt        = orow == '0;
        pos.zb        = or_end;
        pos.row_end   = pos.emit && oc_end;
        pos.frame_end = pos.emit && oc_end && or_end;

        if (col_inc >= w_eff)
        begin
            in_col_next = '0;
            in_row_next = (row == '1) ? row : row + 1'b1;
        end
        else
        begin
            in_col_next = col_inc[CW-1:0];
            in_row_next = row;
        end

        out_col_next = oc;
        out_row_next = orow;
        if (pos.frame_end)
        begin
            // last result of the frame: restart every position
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (pos.row_end)
        begin
            out_col_next = '0;
            out_row_next = orow_inc[RB-1:0];
        end
        else if (pos.emit)
        begin
            out_col_next = oc_inc[CW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake between accept stage, window stage and magnitude pipe
    // ------------------------------------------------------------------
    always_comb
    begin
        // a beat that yields no result leaves without the magnitude pipe
        b_commit     = b_valid_reg && (!b_pos_reg.emit || grad_ready);
        pix_stall    = b_valid_reg && !b_commit;
        pix_accept   = pix_valid && !pix_stall;
        b_valid_next = pix_accept || (b_valid_reg && !b_commit);

        // bypass the line store when the next beat reads the column
        // written back at the same edge; drop it once the beat is gone
        if (pix_accept)
            fwd_next = b_commit && (b_col_reg == col);
        else if (b_commit)
            fwd_next = 1'b0;
        else
            fwd_next = fwd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            win_reg     <= '0;
        end
        else
        begin
            if (pix_accept)
            begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
            b_valid_reg <= b_valid_next;
            fwd_reg     <= fwd_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_accept)
        begin
            b_pix_reg  <= v_in;
            b_col_reg  <= col;
            b_pos_reg  <= pos;
            fwd_up_reg <= lo_cur;
            fwd_lo_reg <= b_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // Line memories: read on accept, write back when the beat commits
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (b_commit)
        begin
            upper_mem[b_col_reg] <= lo_cur;
            lower_mem[b_col_reg] <= b_pix_reg;
        end
        if (pix_accept)
        begin
            rd_up_reg <= upper_mem[col];
            rd_lo_reg <= lower_mem[col];
        end
    end

    // ------------------------------------------------------------------
    // Window stage: neighborhood, border masks and gradients
    // ------------------------------------------------------------------
    always_comb
    begin
        up_cur = fwd_reg ? fwd_up_reg : rd_up_reg;
        lo_cur = fwd_reg ? fwd_lo_reg : rd_lo_reg;

        n00 = (b_pos_reg.zl || b_pos_reg.zt) ? '0 : win_reg[0][0];
        n01 = b_pos_reg.zt                   ? '0 : win_reg[0][1];
        n02 = (b_pos_reg.zr || b_pos_reg.zt) ? '0 : up_cur;
        n10 = b_pos_reg.zl                   ? '0 : win_reg[1][0];
        n12 = b_pos_reg.zr                   ? '0 : lo_cur;
        n20 = (b_pos_reg.zl || b_pos_reg.zb) ? '0 : win_reg[2][0];
        n21 = b_pos_reg.zb                   ? '0 : win_reg[2][1];
        n22 = (b_pos_reg.zr || b_pos_reg.zb) ? '0 : b_pix_reg;

        top_sum   = GW'(n00) + (GW'(n01) << 1) + GW'(n02);
        bot_sum   = GW'(n20) + (GW'(n21) << 1) + GW'(n22);
        left_sum  = GW'(n00) + (GW'(n10) << 1) + GW'(n20);
        right_sum = GW'(n02) + (GW'(n12) << 1) + GW'(n22);
        gy        = $signed(top_sum - bot_sum);
        gx        = $signed(left_sum - right_sum);

        grad_tag.row_end   = b_pos_reg.row_end;
        grad_tag.frame_end = b_pos_reg.frame_end;

        // advance the window by one column; clear it after the frame
        win_next = win_reg;
        if (b_commit)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r][0] = win_reg[r][1];
            end
            win_next[0][1] = up_cur;
            win_next[1][1] = lo_cur;
            win_next[2][1] = b_pix_reg;
            if (b_pos_reg.frame_end)
                win_next = '0;
        end
    end

    sem_mag #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_mag (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (b_valid_reg && b_pos_reg.emit),
        .grad_ready (grad_ready),
        .gx         (gx),
        .gy         (gy),
        .grad_tag   (grad_tag),
        .mag_valid  (mag_valid),
        .mag_stall  (mag_stall),
        .magnitude  (magnitude),
        .mag_tag    (mag_tag)
    );

    assign row_end   = mag_tag.row_end;
    assign frame_end = mag_tag.frame_end;

`ifndef SYNTHESIS
    // the column counter never points past the effective width
    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pix_accept |-> ({1'b0, in_col_next} < w_eff))
        else $error("column counter beyond frame width");

    // the bypass is only live while its beat sits in the window stage
    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> b_valid_reg)
        else $error("line bypass set without a beat in the window stage");

    // input is held back only by a result beat waiting on the magnitude pipe
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pix_stall |-> (b_valid_reg && b_pos_reg.emit && !grad_ready))
        else $error("pixel stall without a blocked result beat");

    // the window starts empty after the last result of a frame
    a_win_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (b_commit && b_pos_reg.frame_end) |=> (win_reg == '0))
        else $error("window not cleared at frame end");

    // a frame ends only at a row end
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        (mag_valid && frame_end) |-> row_end)
        else $error("frame_end without row_end");
`endif

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for sobel_edge_magnitude_top: drives pixel beats,
// predicts every magnitude beat and compares each one as it leaves the block.
// Depends on sem_pkg and the sobel_edge_magnitude_top RTL.
`timescale 1ns / 1ps

module tb;

    localparam int MAX_W          = 1024;
    localparam int PIX_BITS       = 8;
    // Window stage, gradients, squares, sum, then one root bit per stage.
    localparam int PIPE_LATENCY   = PIX_BITS + 6;
    localparam int SETTLE_CYCLES  = 3 * PIPE_LATENCY;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 120;
    localparam int MAX_REPORTS    = 10;

    // One magnitude beat as the block presents it.
    typedef struct packed {
        logic [sem_pkg::MAG_BITS-1:0] magnitude;
        logic                         row_end;
        logic                         frame_end;
    } mag_beat_t;

    logic                               clk = 1'b0;
    logic                               rst_n;
    logic                               cfg_we;
    logic [sem_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [sem_pkg::CFG_DATA_BITS-1:0]  cfg_data;
    logic                               pix_valid;
    logic                               pix_stall;
    logic [PIX_BITS-1:0]                pixel;
    logic                               pad;
    logic                               mag_valid;
    logic                               mag_stall;
    logic [sem_pkg::MAG_BITS-1:0]       magnitude;
    logic                               row_end;
    logic                               frame_end;

    sobel_edge_magnitude_top #(
        .MAX_WIDTH  (MAX_W),
        .PIXEL_BITS (PIX_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pixel     (pixel),
        .pad       (pad),
        .mag_valid (mag_valid),
        .mag_stall (mag_stall),
        .magnitude (magnitude),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Edge-magnitude predictor state: programmed frame size, the two line
    // stores, the 3x3 neighborhood and the input/output raster positions.
    // ------------------------------------------------------------------
    logic [sem_pkg::WIDTH_BITS-1:0]  cur_width  = sem_pkg::WIDTH_RESET;
    logic [sem_pkg::HEIGHT_BITS-1:0] cur_height = sem_pkg::HEIGHT_RESET;
    logic [PIX_BITS-1:0]    older_line [MAX_W] = '{default: '0};
    logic [PIX_BITS-1:0]    newer_line [MAX_W] = '{default: '0};
    logic [PIX_BITS-1:0]    nbhd [3][3] = '{default: '0};
    int unsigned            px_col  = 0;
    int unsigned            px_row  = 0;
    int unsigned            res_col = 0;
    int unsigned            res_row = 0;

    // Magnitude beats predicted but not yet seen at the output.
    mag_beat_t   pending_mags [$];
    int unsigned beats_sent = 0;
    int unsigned mismatches = 0;

    // Idling knobs, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long receiver hold-off: the test bumps the token, the stall process
    // notices it and counts the hold on its own.
    int unsigned hold_token = 0;
    int unsigned hold_seen  = 0;
    int unsigned hold_left  = 0;

    int unsigned quiet_cycles = 0;

    // Out-of-range sizes: width 0 counts as 1, above MAX_W counts as MAX_W;
    // height 0 counts as 1.
    function automatic int unsigned eff_width();
        if (cur_width == 0)
            return 1;
        if (cur_width > MAX_W)
            return MAX_W;
        return cur_width;
    endfunction

    function automatic int unsigned eff_height();
        return (cur_height == 0) ? 1 : cur_height;
    endfunction

    // Bitwise integer square root, floor; the argument stays below 2^22.
    function automatic logic [sem_pkg::MAG_BITS-1:0] isqrt_floor(input int unsigned x);
        int unsigned root;
        int unsigned trial;
        root = 0;
        for (int b = sem_pkg::MAG_BITS - 1; b >= 0; b--)
        begin
            trial = root | (32'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root[sem_pkg::MAG_BITS-1:0];
    endfunction

    // Advance the predictor by one accepted pixel beat; return 1 and fill
    // res when the beat releases a magnitude.
    function automatic bit sobel_predict(input logic [PIX_BITS-1:0] px, input logic pd,
                                         output mag_beat_t res);
        int unsigned         w;
        int unsigned         h;
        int unsigned         col;
        int unsigned         row;
        logic [PIX_BITS-1:0] v;
        logic [PIX_BITS-1:0] up;
        logic [PIX_BITS-1:0] lo;
        int                  n [3][3];
        int                  gx;
        int                  gy;
        bit                  emit;
        bit                  last_col;
        bit                  last_row;

        w   = eff_width();
        h   = eff_height();
        res = '0;
        if (px_col >= w)
        begin
            px_col = 0;
            px_row++;
        end
        if (res_col >= w)
        begin
            res_col = 0;
            res_row++;
        end

        col = px_col;
        row = px_row;
        // Pads and anything below the frame stand for zero pixels.
        v    = (pd || row >= h) ? '0 : px;
        up   = older_line[col];
        lo   = newer_line[col];
        emit = (row >= 2) || (row == 1 && col >= 1);

        if (emit)
        begin
            for (int r = 0; r < 3; r++)
            begin
                n[r][0] = nbhd[r][1];
                n[r][1] = nbhd[r][2];
            end
            n[0][2] = (col == 0) ? 0 : up;
            n[1][2] = (col == 0) ? 0 : lo;
            n[2][2] = (col == 0) ? 0 : v;

            last_col = (res_col + 1 >= w);
            last_row = (res_row + 1 >= h);
            // Mask neighbors outside the frame by output position.
            for (int r = 0; r < 3; r++)
            begin
                if (res_col == 0)
                    n[r][0] = 0;
                if (last_col)
                    n[r][2] = 0;
                if (res_row == 0)
                    n[0][r] = 0;
                if (last_row)
                    n[2][r] = 0;
            end

            gy = (n[0][0] + 2 * n[0][1] + n[0][2]) - (n[2][0] + 2 * n[2][1] + n[2][2]);
            gx = (n[0][0] + 2 * n[1][0] + n[2][0]) - (n[0][2] + 2 * n[1][2] + n[2][2]);
            res.magnitude = isqrt_floor(gx * gx + gy * gy);
            res.row_end   = last_col;
            res.frame_end = last_col && last_row;
        end

        for (int r = 0; r < 3; r++)
        begin
            nbhd[r][0] = nbhd[r][1];
            nbhd[r][1] = nbhd[r][2];
        end
        nbhd[0][2]      = up;
        nbhd[1][2]      = lo;
        nbhd[2][2]      = v;
        older_line[col] = lo;
        newer_line[col] = v;

        px_col++;
        if (px_col >= w)
        begin
            px_col = 0;
            px_row++;
        end
        if (px_row > 32'h3FFF)
            px_row = 32'h3FFF;

        if (emit)
        begin
            if (res.frame_end)
            begin
                px_col  = 0;
                px_row  = 0;
                res_col = 0;
                res_row = 0;
                nbhd    = '{default: '0};
            end
            else if (res.row_end)
            begin
                res_col = 0;
                res_row++;
            end
            else
            begin
                res_col++;
            end
        end
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // Pixel side: offer one beat, hold it until accepted, then predict.
    // valid stays high on return so back-to-back beats need no bubble.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [PIX_BITS-1:0] px, input logic pd);
        mag_beat_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= px;
        pad       <= pd;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        beats_sent++;
        if (sobel_predict(px, pd, res))
            pending_mags.push_back(res);
    endtask

    // Mostly random grey values, with the two extremes weighted up.
    function automatic logic [PIX_BITS-1:0] random_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // Send npix frame pixels (some as in-frame pads) and then nflush pads.
    task automatic send_frame(input int unsigned npix, input int unsigned nflush,
                              input int unsigned pad_pct);
        for (int unsigned i = 0; i < npix; i++)
            send_beat(random_pixel(), $urandom_range(0, 99) < pad_pct);
        for (int unsigned i = 0; i < nflush; i++)
            send_beat(PIX_BITS'($urandom_range(0, 255)), 1'b1);
    endtask

    // Pad until the predictor sits at the start of a fresh frame.
    task automatic finish_frame();
        while (px_col != 0 || px_row != 0 || res_col != 0 || res_row != 0)
            send_beat(PIX_BITS'($urandom_range(0, 255)), 1'b1);
    endtask

    // Drop valid, wait for every predicted beat, then let the pipe settle.
    task automatic wait_drained();
        pix_valid <= 1'b0;
        while (pending_mags.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Write both size registers on consecutive edges; only while idle.
    task automatic program_frame(input logic [sem_pkg::CFG_DATA_BITS-1:0] wval,
                                 input logic [sem_pkg::CFG_DATA_BITS-1:0] hval);
        cfg_we    <= 1'b1;
        cfg_index <= sem_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= wval;
        @(posedge clk);
        cfg_index <= sem_pkg::CFG_FRAME_HEIGHT;
        cfg_data  <= hval;
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_width  = wval[sem_pkg::WIDTH_BITS-1:0];
        cur_height = hval[sem_pkg::HEIGHT_BITS-1:0];
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Tiny frames: every border position, pixel extremes, a pad inside the
    // frame, and a non-pad beat below the frame (must read as zero).
    task automatic test_directed_borders();
        logic [PIX_BITS-1:0] corner [9] = '{8'd255, 8'd255, 8'd0,
                                            8'd255, 8'd0,   8'd0,
                                            8'd0,   8'd0,   8'd255};
        program_frame(13'd3, 13'd3);
        for (int i = 0; i < 9; i++)
            send_beat(corner[i], 1'b0);
        send_frame(0, 4, 0);
        wait_drained();

        // Single-pixel frame; the flush mixes a pad and a plain beat.
        program_frame(13'd1, 13'd1);
        send_beat(8'd255, 1'b0);
        send_beat(8'h5A, 1'b1);
        send_beat(8'd255, 1'b0);
        wait_drained();

        // 2x2 frame with a pad carrying a full-scale value inside the frame.
        program_frame(13'd2, 13'd2);
        send_beat(8'd200, 1'b0);
        send_beat(8'd255, 1'b1);
        send_beat(8'd17, 1'b0);
        send_beat(8'd255, 1'b0);
        send_frame(0, 3, 0);
        wait_drained();
    endtask

    // Register extremes: zero width and zero height (both count as one),
    // then a width whose register bits are zero under set upper data bits.
    task automatic test_register_extremes();
        program_frame(13'd0, 13'd0);
        send_frame(eff_width() * eff_height(), eff_width() + 1, 3);
        wait_drained();
        program_frame(13'h1800, 13'd6);
        send_frame(eff_width() * eff_height(), eff_width() + 1, 3);
        wait_drained();
    endtask

    // Hold the result side off for a long stretch while pixels keep coming,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        program_frame(13'd16, 13'd6);
        hold_token++;
        send_frame(16 * 6, 17, 0);
        wait_drained();
    endtask

    // Random frames of mostly small sizes. Most are well formed; some get a
    // short or long flush so that frames run into each other.
    task automatic test_random_frames(input int unsigned goal);
        int unsigned first;
        int unsigned sel;
        int unsigned w;
        int unsigned h;
        int unsigned flush;
        logic [sem_pkg::CFG_DATA_BITS-1:0] wval;
        logic [sem_pkg::CFG_DATA_BITS-1:0] hval;
        bit resize;

        first  = beats_sent;
        resize = 1'b1;
        while (beats_sent - first < goal)
        begin
            if (resize)
            begin
                finish_frame();
                wait_drained();
                sel = $urandom_range(0, 19);
                if (sel < 15)
                    w = $urandom_range(1, 8);
                else
                    w = $urandom_range(9, 40);
                // Upper data bits are outside the width register; toggle them.
                wval = {2'($urandom_range(0, 3)), 11'(w)};
                sel  = $urandom_range(0, 19);
                if (sel < 2)
                    h = 0;
                else if (sel < 15)
                    h = $urandom_range(1, 5);
                else
                    h = $urandom_range(6, 10);
                hval = 13'(h);
                program_frame(wval, hval);
            end
            w = eff_width();
            h = eff_height();
            flush = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * w + 2) : w + 1;
            send_frame(w * h, flush, 5);
            resize = $urandom_range(0, 1);
        end
        finish_frame();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Result side: stall at random, or hold off for a counted stretch.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_token != hold_seen)
        begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            mag_stall <= 1'b1;
        end
        else
        begin
            mag_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare every accepted magnitude beat with the oldest prediction.
    always @(posedge clk)
    begin
        mag_beat_t want;
        if (rst_n && mag_valid && !mag_stall)
        begin
            if (pending_mags.size() == 0)
            begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected beat: mag %0d row_end %0b frame_end %0b",
                             $time, magnitude, row_end, frame_end);
                mismatches++;
            end
            else
            begin
                want = pending_mags.pop_front();
                if (magnitude !== want.magnitude || row_end !== want.row_end ||
                    frame_end !== want.frame_end)
                begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                                 $time, want.magnitude, want.row_end, want.frame_end,
                                 magnitude, row_end, frame_end);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (mag_valid && !mag_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sobel_edge_magnitude_top verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset once, directed tests, then random frames in each
    // idling phase, then drain and report.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= sem_pkg::CFG_FRAME_WIDTH;
        cfg_data  <= '0;
        pix_valid <= 1'b0;
        pixel     <= '0;
        pad       <= 1'b0;
        mag_stall <= 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(posedge clk);

        set_idling(0, 0);
        test_directed_borders();
        set_idling(16, 16);
        test_register_extremes();
        set_idling(0, 0);
        test_backpressure();

        set_idling(0, 0);
        test_random_frames(PHASE_ITEMS);
        set_idling(85, 0);
        test_random_frames(PHASE_ITEMS);
        set_idling(0, 85);
        test_random_frames(PHASE_ITEMS);
        set_idling(16, 16);
        test_random_frames(PHASE_ITEMS);

        wait_drained();
        if (mismatches == 0 && pending_mags.size() == 0)
            $display("sobel_edge_magnitude_top verification clean");
        else
            $display("sobel_edge_magnitude_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sem_pkg.sv
rtl/sem_mag.sv
rtl/sobel_edge_magnitude_top.sv
verif/tb.sv
